/* hw/rtl/rtc_fields_to_epoch_unit_defines.svh */
// ----------------------------------------------------------------------------
// rtc_fields_to_epoch_unit_defines.svh
// Assertion macros shared by the date to epoch converter RTL.
// ----------------------------------------------------------------------------
`ifndef RTC_FIELDS_TO_EPOCH_UNIT_DEFINES_SVH
`define RTC_FIELDS_TO_EPOCH_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define RFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfe: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define RFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfe: next-cycle check failed");

`else

`define RFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/rfe_pkg.sv */
// ----------------------------------------------------------------------------
// rfe_pkg
// Types, constants and decode helpers for the date to epoch converter.
// ----------------------------------------------------------------------------
package rfe_pkg;

    localparam int EPOCH_W     = 33;
    localparam int SUM_W       = 35;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 1;

    // Years 1970..1999 hold seven leap years
    localparam logic [7:0]       LEAPS_BEFORE_2000 = 8'd7;
    localparam logic [8:0]       YEARS_1970_TO_2000 = 9'd30;
    localparam logic [SUM_W-1:0] SECS_PER_YEAR = 35'd31536000;
    localparam logic [SUM_W-1:0] SECS_PER_DAY  = 35'd86400;
    localparam logic [SUM_W-1:0] SECS_PER_HOUR = 35'd3600;
    localparam logic [SUM_W-1:0] SECS_PER_MIN  = 35'd60;
    localparam logic [SUM_W-1:0] EPOCH_MAX     = 35'h1_FFFF_FFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BINARY_MODE = 2'd0,
        REG_HOUR24_MODE = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] second_raw;
        logic [7:0] minute_raw;
        logic [7:0] hour_raw;
        logic [7:0] day_raw;
        logic [7:0] month_raw;
        logic [7:0] year_raw;
    } item_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch_seconds;
        logic               bad_date;
    } result_t;

    typedef struct packed {
        logic binary_mode;
        logic hour24_mode;
    } cfg_t;

    // Two BCD digits, no nibble check: tens * 10 + ones
    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        from_bcd = 8'(v[3:0]) + 8'({v[7:4], 3'b000}) + 8'({v[7:4], 1'b0});
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] m0);
        case (m0)
            4'd0:    days_before_month = 9'd0;
            4'd1:    days_before_month = 9'd31;
            4'd2:    days_before_month = 9'd59;
            4'd3:    days_before_month = 9'd90;
            4'd4:    days_before_month = 9'd120;
            4'd5:    days_before_month = 9'd151;
            4'd6:    days_before_month = 9'd181;
            4'd7:    days_before_month = 9'd212;
            4'd8:    days_before_month = 9'd243;
            4'd9:    days_before_month = 9'd273;
            4'd10:   days_before_month = 9'd304;
            4'd11:   days_before_month = 9'd334;
            default: days_before_month = 9'd0;
        endcase
    endfunction

endpackage

/* hw/rtl/rtc_fields_to_epoch_unit.sv */
// ----------------------------------------------------------------------------
// rtc_fields_to_epoch_unit
// Clock-chip date/time bytes in, Unix seconds since 1970 out.
// ----------------------------------------------------------------------------
//
//  channel   signals                                  beat carries
//  -------   ---------------------------------------  ------------------------
//  item      item_valid, item_ready, item             six raw date/time bytes
//  result    result_valid, result_ready, result       epoch seconds, bad flag
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  mode register write
//
//  One item per cycle sustained while result_ready is high; each result
//  passes the input register, then the result register. The whole
//  conversion sits in one combinational pass between those two registers.
//  Reset clears both valid flags and loads BCD, 24-hour mode.
//  A stalled result holds its register; the input register keeps taking a
//  beat as long as it can move forward, so item_ready drops only when both
//  stages are full and result_ready is low.
//
`include "rtc_fields_to_epoch_unit_defines.svh"

module rtc_fields_to_epoch_unit
    import rfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,

    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    item_t   item_reg;
    logic    item_valid_reg;
    logic    item_valid_next;
    result_t result_reg;
    result_t result_next;
    result_t conv_out;
    logic    result_valid_reg;
    logic    result_valid_next;
    logic    advance;
    logic    item_take;

    // Result register frees up when empty or being drained this cycle
    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = !item_valid_reg || advance;
    assign item_take  = item_valid && item_ready;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    rfe_convert u_convert (
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (conv_out)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BINARY_MODE: cfg_next.binary_mode = cfg_data[0];
                REG_HOUR24_MODE: cfg_next.hour24_mode = cfg_data[0];
                default:         cfg_next = cfg_reg;  // drop unknown index
            endcase
        end

        // Input stage: fill on a beat, empty when it moves on
        if (item_take)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;

        // Result stage: load on advance, hold while stalled
        if (advance)
        begin
            result_valid_next = item_valid_reg;
            result_next       = conv_out;
        end
        else
        begin
            result_valid_next = result_valid_reg;
            result_next       = result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.binary_mode <= 1'b0;
            cfg_reg.hour24_mode <= 1'b1;
            item_valid_reg      <= 1'b0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
        result_reg <= result_next;
    end

    `RFE_ASSERT_NEXT(a_take_fills, clk, rst_n, item_take, item_valid_reg)
    `RFE_ASSERT_NEXT(a_stage_moves, clk, rst_n, item_valid_reg && advance, result_valid_reg)
    `RFE_ASSERT_NOW(a_bad_is_zero, clk, rst_n,
                    result_valid_reg && result_reg.bad_date,
                    result_reg.epoch_seconds == '0)
    `RFE_ASSERT_NEXT(a_cfg_bin, clk, rst_n,
                     cfg_valid && (cfg_index == REG_BINARY_MODE),
                     cfg_reg.binary_mode == $past(cfg_data[0]))

endmodule

/* hw/rtl/rfe_convert.sv */
// ----------------------------------------------------------------------------
// rfe_convert
// Decode one set of clock-chip bytes and form Unix seconds in closed form.
// ----------------------------------------------------------------------------
module rfe_convert
    import rfe_pkg::*;
(
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [7:0]       sec_d;
    logic [7:0]       min_d;
    logic [7:0]       day_d;
    logic [7:0]       mon_d;
    logic [7:0]       yr_d;
    logic [6:0]       hr_d;
    logic [7:0]       hr_bcd;
    logic             pm;
    logic [5:0]       hr_fold;
    logic [3:0]       hr_mod12;
    logic [6:0]       hr_final;
    logic             bad;
    logic [8:0]       year_ofs;
    logic [7:0]       leaps;
    logic             leap_year;
    logic             leap_add;
    logic [9:0]       day_rem;
    logic [SUM_W-1:0] total;

    always_comb
    begin
        hr_bcd = from_bcd({1'b0, item.hour_raw[6:0]});
        if (cfg.binary_mode)
        begin
            sec_d = item.second_raw;
            min_d = item.minute_raw;
            day_d = item.day_raw;
            mon_d = item.month_raw;
            yr_d  = item.year_raw;
            hr_d  = item.hour_raw[6:0];
        end
        else
        begin
            sec_d = from_bcd(item.second_raw);
            min_d = from_bcd(item.minute_raw);
            day_d = from_bcd(item.day_raw);
            mon_d = from_bcd(item.month_raw);
            yr_d  = from_bcd(item.year_raw);
            hr_d  = hr_bcd[6:0];
        end
        pm = item.hour_raw[7];

        // 16 = 4 mod 12: fold the high digit, then subtract 36, 24 or 12 at most once
        hr_fold = 6'({hr_d[6:4], 2'b00}) + 6'(hr_d[3:0]);
        if (hr_fold >= 6'd36)
            hr_mod12 = 4'(hr_fold - 6'd36);
        else if (hr_fold >= 6'd24)
            hr_mod12 = 4'(hr_fold - 6'd24);
        else if (hr_fold >= 6'd12)
            hr_mod12 = 4'(hr_fold - 6'd12);
        else
            hr_mod12 = hr_fold[3:0];

        hr_final = hr_d;
        if (!cfg.hour24_mode)
        begin
            if (pm)
                hr_final = 7'(hr_mod12) + 7'd12;
            else if (hr_d == 7'd12)
                hr_final = 7'd0;
        end

        bad = (mon_d == 8'd0) || (mon_d > 8'd12) || (day_d == 8'd0);

        // Leap years 1970..year-1: seven up to 1999, then multiples of four
        // from 2000, less the centuries 2100 and 2200
        year_ofs  = 9'(yr_d) + YEARS_1970_TO_2000;
        leaps     = LEAPS_BEFORE_2000 + 8'((9'(yr_d) + 9'd3) >> 2)
                  - 8'(yr_d >= 8'd101) - 8'(yr_d >= 8'd201);
        leap_year = (yr_d[1:0] == 2'b00) && (yr_d != 8'd100) && (yr_d != 8'd200);
        leap_add  = leap_year && (mon_d > 8'd2);
        day_rem   = 10'(leaps) + 10'(days_before_month(4'(mon_d - 8'd1)))
                  + 10'(leap_add) + 10'(day_d) - 10'd1;

        total = SUM_W'(year_ofs) * SECS_PER_YEAR
              + SUM_W'(day_rem) * SECS_PER_DAY
              + SUM_W'(hr_final) * SECS_PER_HOUR
              + SUM_W'(min_d) * SECS_PER_MIN
              + SUM_W'(sec_d);

        if (bad)
        begin
            result.epoch_seconds = '0;
            result.bad_date      = 1'b1;
        end
        else
        begin
            result.epoch_seconds = (total > EPOCH_MAX) ? EPOCH_MAX[EPOCH_W-1:0]
                                                       : total[EPOCH_W-1:0];
            result.bad_date      = 1'b0;
        end
    end

endmodule
